// File: hw/rtl/dst_rule_evaluator_assert.svh
// assertion macros for the dst rule evaluator
`ifndef DST_RULE_EVALUATOR_ASSERT_SVH
`define DST_RULE_EVALUATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DRE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DRE_ASSERT_NEXT(label, clk, rstn, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cause) |=> (effect)) \
        else $error(msg);
`else
`define DRE_ASSERT(label, clk, rstn, prop, msg)
`define DRE_ASSERT_NEXT(label, clk, rstn, cause, effect, msg)
`endif
`endif

// File: hw/rtl/dre_pkg.sv
package dre_pkg;

    localparam int YEAR_W     = 15;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int WDAY_W     = 3;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int YDAY_W     = 9;
    localparam int BIAS_W     = 12;
    localparam int OFFSET_W   = 19;
    localparam int RULE_W     = 37;
    localparam int CFG_ADDR_W = 3;
    localparam int Q25_W      = 11;
    localparam int CHG_W      = 7;

    // reciprocal of 25 scaled by 2^20, exact for all 15-bit years
    localparam logic [15:0] RECIP_25 = 16'd41944;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DAYLIGHT_RULE  = 3'd0,
        CFG_STANDARD_RULE  = 3'd1,
        CFG_BASE_BIAS      = 3'd2,
        CFG_STANDARD_EXTRA = 3'd3,
        CFG_DAYLIGHT_EXTRA = 3'd4
    } cfg_addr_t;

    // order of the date against a rule's transition, as far as compared so far
    typedef enum logic [1:0] {
        ORD_LESS  = 2'd0,
        ORD_EQUAL = 2'd1,
        ORD_MORE  = 2'd2
    } ord_t;

    typedef struct packed {
        logic [15:0]         year;
        logic [MONTH_W-1:0]  month;
        logic [2:0]          week;
        logic [WDAY_W-1:0]   wday;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } rule_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [Q25_W-1:0]    q25;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic                utc;
        logic                late_month;
        logic [YDAY_W-1:0]   yday_base;
        logic [2:0]          sun;
        ord_t                dl_ord;
        ord_t                st_ord;
    } s1_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic                utc;
        logic [YDAY_W-1:0]   yday;
        ord_t                dl_ord;
        ord_t                st_ord;
    } s2_t;

    // first day of a zero-based month, non-leap
    function automatic logic [YDAY_W-1:0] month_start(input logic [MONTH_W-1:0] idx);
        logic [YDAY_W-1:0] r;
        case (idx)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd365;
        endcase
        return r;
    endfunction

    // non-leap length of a one-based month, 31 outside the year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:                      r = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction

    // x mod 7 for six-bit x by reciprocal multiply
    function automatic logic [2:0] mod7(input logic [5:0] x);
        logic [11:0] p;
        logic [3:0]  q;
        logic [6:0]  q7;
        logic [5:0]  r;
        p  = {6'd0, x} * 12'd37;
        q  = p[11:8];
        q7 = {q, 3'b000} - {3'b000, q};
        r  = x - q7[5:0];
        return r[2:0];
    endfunction

    function automatic ord_t prefix_ord(input logic [YEAR_W-1:0] year,
                                        input logic [MONTH_W-1:0] month,
                                        input rule_t r);
        ord_t o;
        if (r.year != 16'd0 && {1'b0, year} < r.year) begin
            o = ORD_LESS;
        end else if (r.year != 16'd0 && {1'b0, year} > r.year) begin
            o = ORD_MORE;
        end else if (month < r.month) begin
            o = ORD_LESS;
        end else if (month > r.month) begin
            o = ORD_MORE;
        end else begin
            o = ORD_EQUAL;
        end
        return o;
    endfunction

    // day of month of the transition, given the sunday of this week as a day of month mod 7
    function automatic logic signed [CHG_W-1:0] change_day(input logic [2:0] sun,
                                                           input rule_t r);
        logic [3:0]               c;
        logic [5:0]               wk7;
        logic signed [CHG_W-1:0]  chg;
        c = {1'b0, sun} + {1'b0, r.wday};
        if (c >= 4'd7) begin
            c = c - 4'd7;
        end
        if (c == 4'd0) begin
            c = 4'd7;
        end
        wk7 = {r.week, 3'b000} - {3'b000, r.week};
        chg = $signed({3'b000, c}) + $signed({1'b0, wk7}) - 7'sd7;
        if (chg > $signed({2'b00, month_len(r.month)})) begin
            chg = chg - 7'sd7;
        end
        return chg;
    endfunction

    function automatic ord_t day_ord(input ord_t prefix, input logic [DAY_W-1:0] day,
                                     input logic signed [CHG_W-1:0] chg);
        ord_t o;
        o = prefix;
        if (prefix == ORD_EQUAL) begin
            if ($signed({2'b00, day}) < chg) begin
                o = ORD_LESS;
            end else if ($signed({2'b00, day}) > chg) begin
                o = ORD_MORE;
            end
        end
        return o;
    endfunction

    // date strictly before the rule's transition
    function automatic logic before_rule(input ord_t o, input logic [HOUR_W-1:0] hour,
                                         input logic [MINUTE_W-1:0] minute,
                                         input rule_t r);
        logic b;
        unique case (o)
            ORD_LESS:  b = 1'b1;
            ORD_MORE:  b = 1'b0;
            ORD_EQUAL: b = ({hour, minute} < {r.hour, r.minute});
            default:   b = 1'b0;
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/dst_rule_evaluator.sv
// Daylight saving time rule evaluator. Each input word is a broken-down local date (year,
// month, day, weekday, hour, minute) with a UTC flag in tuser; each result word gives the
// daylight flag, the zone offset in seconds (local minus UTC) and the zero-based day of year.
// Two rules are programmed through the write port: daylight start and standard start,
// each packed as year16 (0 = every year), month4, week3 (5 = last), weekday3, hour5,
// minute6. A standard month of zero turns daylight time off. One word is accepted every
// clock cycle while the result side takes its words; the three register stages are date
// prep, transition day, and decision and offset; backpressure on the result side stalls
// the stages one by one, so empty stages keep accepting. Rules and biases must only be
// written while no word is in flight.
`include "dst_rule_evaluator_assert.svh"

module dst_rule_evaluator import dre_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // year[14:0], month[18:15], day[23:19], weekday[26:24], hour[31:27], minute[37:32]
    input  logic [39:0]           s_axis_tdata,
    // utc_mode[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // is_daylight[0], local_offset[19:1], year_day[28:20]
    output logic [31:0]           m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [RULE_W-1:0]     cfg_wdata
);

    rule_t                      dl_rule_reg;
    rule_t                      st_rule_reg;
    logic signed [BIAS_W-1:0]   base_bias_reg;
    logic signed [BIAS_W-1:0]   std_extra_reg;
    logic signed [BIAS_W-1:0]   dl_extra_reg;

    logic                       s1_valid;
    logic                       s1_ready;
    s1_t                        s1_data;
    logic                       s2_valid;
    logic                       s2_ready;
    s2_t                        s2_data;
    logic                       is_daylight;
    logic signed [OFFSET_W-1:0] local_offset;
    logic [YDAY_W-1:0]          year_day;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dl_rule_reg   <= '0;
            st_rule_reg   <= '0;
            base_bias_reg <= '0;
            std_extra_reg <= '0;
            dl_extra_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_DAYLIGHT_RULE:  dl_rule_reg   <= rule_t'(cfg_wdata);
                CFG_STANDARD_RULE:  st_rule_reg   <= rule_t'(cfg_wdata);
                CFG_BASE_BIAS:      base_bias_reg <= cfg_wdata[BIAS_W-1:0];
                CFG_STANDARD_EXTRA: std_extra_reg <= cfg_wdata[BIAS_W-1:0];
                CFG_DAYLIGHT_EXTRA: dl_extra_reg  <= cfg_wdata[BIAS_W-1:0];
                default: ;
            endcase
        end
    end

    dre_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .year      (s_axis_tdata[14:0]),
        .month     (s_axis_tdata[18:15]),
        .day       (s_axis_tdata[23:19]),
        .weekday   (s_axis_tdata[26:24]),
        .hour      (s_axis_tdata[31:27]),
        .minute    (s_axis_tdata[37:32]),
        .utc_mode  (s_axis_tuser),
        .dl_rule   (dl_rule_reg),
        .st_rule   (st_rule_reg),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    dre_change u_change (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .dl_rule   (dl_rule_reg),
        .st_rule   (st_rule_reg),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    dre_decide u_decide (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_valid            (s2_valid),
        .in_ready            (s2_ready),
        .in_data             (s2_data),
        .dl_rule             (dl_rule_reg),
        .st_rule             (st_rule_reg),
        .base_bias           (base_bias_reg),
        .standard_extra_bias (std_extra_reg),
        .daylight_extra_bias (dl_extra_reg),
        .out_valid           (m_axis_tvalid),
        .out_ready           (m_axis_tready),
        .is_daylight         (is_daylight),
        .local_offset        (local_offset),
        .year_day            (year_day)
    );

    assign m_axis_tdata = {3'b000, year_day, local_offset, is_daylight};

    // input side only stalls when every stage holds a word and the sink holds off
    `DRE_ASSERT(a_stall_only_when_full, aclk, aresetn, s_axis_tready || (s1_valid && s2_valid && m_axis_tvalid && !m_axis_tready), "input stalled with room in the pipe")

endmodule

// File: hw/rtl/dre_prep.sv
`include "dst_rule_evaluator_assert.svh"

module dre_prep import dre_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [YEAR_W-1:0]   year,
    input  logic [MONTH_W-1:0]  month,
    input  logic [DAY_W-1:0]    day,
    input  logic [WDAY_W-1:0]   weekday,
    input  logic [HOUR_W-1:0]   hour,
    input  logic [MINUTE_W-1:0] minute,
    input  logic                utc_mode,
    input  rule_t               dl_rule,
    input  rule_t               st_rule,
    output logic                out_valid,
    input  logic                out_ready,
    output s1_t                 out_data
);

    logic              valid_reg;
    logic              valid_next;
    s1_t               s1_reg;
    s1_t               s1_next;
    logic [MONTH_W-1:0] mi;
    logic [YDAY_W-1:0] ysum;
    logic [30:0]       yprod;
    logic [5:0]        sun_raw;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb begin
        mi = month;
        if (month == 4'd0) begin
            mi = 4'd1;
        end else if (month > 4'd12) begin
            mi = 4'd12;
        end
        ysum    = month_start(mi - 4'd1) + {4'd0, day};
        yprod   = {16'd0, year} * {15'd0, RECIP_25};
        sun_raw = {1'b0, day} + 6'd7 - {3'd0, weekday};

        s1_next.year       = year;
        s1_next.q25        = yprod[30:20];
        s1_next.day        = day;
        s1_next.hour       = hour;
        s1_next.minute     = minute;
        s1_next.utc        = utc_mode;
        s1_next.late_month = (month > 4'd2);
        // day zero in january stays at zero
        s1_next.yday_base  = (ysum == 9'd0) ? 9'd0 : ysum - 9'd1;
        s1_next.sun        = mod7(sun_raw);
        s1_next.dl_ord     = prefix_ord(year, month, dl_rule);
        s1_next.st_ord     = prefix_ord(year, month, st_rule);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            s1_reg <= s1_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = s1_reg;

    `DRE_ASSERT(a_yday_base_range, aclk, aresetn, !valid_reg || s1_reg.yday_base <= 9'd365, "year day base out of range")
    `DRE_ASSERT(a_sun_range, aclk, aresetn, !valid_reg || s1_reg.sun <= 3'd6, "sunday residue out of range")

endmodule

// File: hw/rtl/dre_change.sv
`include "dst_rule_evaluator_assert.svh"

module dre_change import dre_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  s1_t   in_data,
    input  rule_t dl_rule,
    input  rule_t st_rule,
    output logic  out_valid,
    input  logic  out_ready,
    output s2_t   out_data
);

    logic                    valid_reg;
    logic                    valid_next;
    s2_t                     s2_reg;
    s2_t                     s2_next;
    logic signed [CHG_W-1:0] dl_chg;
    logic signed [CHG_W-1:0] st_chg;
    logic [15:0]             q25x;
    logic                    div25;
    logic                    leap;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb begin
        dl_chg = change_day(in_data.sun, dl_rule);
        st_chg = change_day(in_data.sun, st_rule);
        q25x   = {1'b0, in_data.q25, 4'd0} + {2'b00, in_data.q25, 3'd0}
               + {5'd0, in_data.q25};
        div25  = (q25x == {1'b0, in_data.year});
        // divisible by 400 is divisible by 25 and by 16
        leap   = (in_data.year[1:0] == 2'b00) && (!div25 || in_data.year[3:0] == 4'd0);

        s2_next.hour   = in_data.hour;
        s2_next.minute = in_data.minute;
        s2_next.utc    = in_data.utc;
        s2_next.yday   = in_data.yday_base + {8'd0, in_data.late_month && leap};
        s2_next.dl_ord = day_ord(in_data.dl_ord, in_data.day, dl_chg);
        s2_next.st_ord = day_ord(in_data.st_ord, in_data.day, st_chg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = s2_reg;

    `DRE_ASSERT(a_dl_chg_range, aclk, aresetn, !in_valid || (dl_chg <= 7'sd42 && dl_chg >= -7'sd6), "daylight change day out of range")
    `DRE_ASSERT(a_st_chg_range, aclk, aresetn, !in_valid || (st_chg <= 7'sd42 && st_chg >= -7'sd6), "standard change day out of range")

endmodule

// File: hw/rtl/dre_decide.sv
`include "dst_rule_evaluator_assert.svh"

module dre_decide import dre_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  s2_t                        in_data,
    input  rule_t                      dl_rule,
    input  rule_t                      st_rule,
    input  logic signed [BIAS_W-1:0]   base_bias,
    input  logic signed [BIAS_W-1:0]   standard_extra_bias,
    input  logic signed [BIAS_W-1:0]   daylight_extra_bias,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       is_daylight,
    output logic signed [OFFSET_W-1:0] local_offset,
    output logic [YDAY_W-1:0]          year_day
);

    logic                       valid_reg;
    logic                       valid_next;
    logic                       dst_reg;
    logic                       dst_next;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic signed [OFFSET_W-1:0] offset_next;
    logic [YDAY_W-1:0]          yday_reg;
    logic                       before_dl;
    logic                       before_st;
    logic                       northern;
    logic signed [BIAS_W:0]     bias_sum;
    logic signed [OFFSET_W-1:0] bias_wide;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb begin
        before_dl = before_rule(in_data.dl_ord, in_data.hour, in_data.minute, dl_rule);
        before_st = before_rule(in_data.st_ord, in_data.hour, in_data.minute, st_rule);
        // whole rule words compare year down to minute
        northern  = (dl_rule < st_rule);
        dst_next  = 1'b0;
        if (!in_data.utc && st_rule.month != 4'd0) begin
            dst_next = northern ? (!before_dl && before_st) : (before_st || !before_dl);
        end
        bias_sum  = {base_bias[BIAS_W-1], base_bias}
                  + (dst_next ? {daylight_extra_bias[BIAS_W-1], daylight_extra_bias}
                              : {standard_extra_bias[BIAS_W-1], standard_extra_bias});
        bias_wide = {{(OFFSET_W-BIAS_W-1){bias_sum[BIAS_W]}}, bias_sum};
        // times minus sixty: 4x - 64x
        offset_next = in_data.utc ? '0 : (bias_wide <<< 2) - (bias_wide <<< 6);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            dst_reg    <= dst_next;
            offset_reg <= offset_next;
            yday_reg   <= in_data.yday;
        end
    end

    assign out_valid    = valid_reg;
    assign is_daylight  = dst_reg;
    assign local_offset = offset_reg;
    assign year_day     = yday_reg;

    `DRE_ASSERT_NEXT(a_load_gives_word, aclk, aresetn, in_valid && in_ready, valid_reg, "accepted word not held in output stage")
    `DRE_ASSERT(a_utc_no_daylight, aclk, aresetn, !(in_valid && in_data.utc) || !dst_next, "daylight set in utc mode")

endmodule

// File: dv/dst_zone_checker.sv
module dst_zone_checker import dre_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // year[14:0], month[18:15], day[23:19], weekday[26:24], hour[31:27], minute[37:32]
    input  logic [39:0]           s_axis_tdata,
    // utc_mode[0]
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // is_daylight[0], local_offset[19:1], year_day[28:20]
    input  logic [31:0]           m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [RULE_W-1:0]     cfg_wdata,
    output int                    mismatches,
    output int                    in_flight
);

    typedef struct packed {
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [WDAY_W-1:0]   wday;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } date_t;

    typedef struct packed {
        logic [YDAY_W-1:0]          year_day;
        logic signed [OFFSET_W-1:0] local_offset;
        logic                       is_daylight;
    } zone_t;

    rule_t              dl_rule;
    rule_t              st_rule;
    logic signed [11:0] base_bias;
    logic signed [11:0] std_extra;
    logic signed [11:0] dst_extra;
    zone_t              zone_due[$];
    int                 errs;

    function automatic int month_first(input int m);
        int r;
        case (m)
            0:       r = 0;
            1:       r = 31;
            2:       r = 59;
            3:       r = 90;
            4:       r = 120;
            5:       r = 151;
            6:       r = 181;
            7:       r = 212;
            8:       r = 243;
            9:       r = 273;
            10:      r = 304;
            11:      r = 334;
            default: r = 365;
        endcase
        return r;
    endfunction

    // date strictly earlier than the change point of rule r
    function automatic logic before_change(input date_t d, input rule_t r);
        int sun;
        int chg;
        int len;
        if (r.year != 16'd0) begin
            if ({1'b0, d.year} < r.year) return 1'b1;
            if ({1'b0, d.year} > r.year) return 1'b0;
        end
        if (d.month < r.month) return 1'b1;
        if (d.month > r.month) return 1'b0;
        sun = (int'(d.day) + 7 - int'(d.wday)) % 7;
        chg = (sun + int'(r.wday)) % 7;
        if (chg == 0) chg = 7;
        chg = chg + (int'(r.week) - 1) * 7;
        if (r.month >= 4'd1 && r.month <= 4'd12) begin
            len = month_first(int'(r.month)) - month_first(int'(r.month) - 1);
        end else begin
            len = 31;
        end
        // last-week rules and overlong weeks fall back into the month
        if (chg > len) chg = chg - 7;
        if (int'(d.day) < chg) return 1'b1;
        if (int'(d.day) > chg) return 1'b0;
        if (d.hour < r.hour) return 1'b1;
        if (d.hour > r.hour) return 1'b0;
        return d.minute < r.minute;
    endfunction

    function automatic zone_t predict_zone(input date_t d, input logic utc);
        int    mi;
        int    yd;
        logic  leap;
        logic  dst;
        int    bias_sum;
        zone_t z;
        mi = (d.month < 4'd1) ? 1 : ((d.month > 4'd12) ? 12 : int'(d.month));
        yd = month_first(mi - 1) + int'(d.day) - 1;
        if (yd < 0) yd = 0;
        leap = (d.year % 4 == 0) && ((d.year % 100 != 0) || (d.year % 400 == 0));
        if (d.month > 4'd2 && leap) yd = yd + 1;
        dst = 1'b0;
        bias_sum = 0;
        if (!utc) begin
            if (st_rule.month != 4'd0) begin
                // northern when the daylight start sorts first, ties go southern
                if (dl_rule < st_rule) begin
                    dst = !before_change(d, dl_rule) && before_change(d, st_rule);
                end else begin
                    dst = before_change(d, st_rule) || !before_change(d, dl_rule);
                end
            end
            bias_sum = int'(base_bias) + (dst ? int'(dst_extra) : int'(std_extra));
        end
        z.is_daylight  = dst;
        z.local_offset = OFFSET_W'(bias_sum * -60);
        z.year_day     = YDAY_W'(yd);
        return z;
    endfunction

    always @(posedge aclk) begin : watch
        zone_t got;
        zone_t want;
        if (!aresetn) begin
            dl_rule   = '0;
            st_rule   = '0;
            base_bias = '0;
            std_extra = '0;
            dst_extra = '0;
            errs      = 0;
            zone_due.delete();
            mismatches <= 0;
            in_flight  <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_DAYLIGHT_RULE:  dl_rule   = cfg_wdata;
                    CFG_STANDARD_RULE:  st_rule   = cfg_wdata;
                    CFG_BASE_BIAS:      base_bias = cfg_wdata[BIAS_W-1:0];
                    CFG_STANDARD_EXTRA: std_extra = cfg_wdata[BIAS_W-1:0];
                    CFG_DAYLIGHT_EXTRA: dst_extra = cfg_wdata[BIAS_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[28:0];
                if (zone_due.size() == 0) begin
                    errs = errs + 1;
                    $display("%0t: result word with none due, expected nothing actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = zone_due.pop_front();
                    if (got.is_daylight !== want.is_daylight) begin
                        errs = errs + 1;
                        $display("%0t: is_daylight expected %0d actual %0d",
                                 $time, want.is_daylight, got.is_daylight);
                    end
                    if (got.local_offset !== want.local_offset) begin
                        errs = errs + 1;
                        $display("%0t: local_offset expected %0d actual %0d", $time,
                                 $signed(want.local_offset), $signed(got.local_offset));
                    end
                    if (got.year_day !== want.year_day) begin
                        errs = errs + 1;
                        $display("%0t: year_day expected %0d actual %0d",
                                 $time, want.year_day, got.year_day);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                zone_due.push_back(predict_zone(s_axis_tdata[37:0], s_axis_tuser));
            end
            mismatches <= errs;
            in_flight  <= zone_due.size();
        end
    end

endmodule

// File: dv/tb_top.sv
module tb_top;
    import dre_pkg::*;

    localparam int MAX_CYCLES  = 100000;
    localparam int HOLD_CYCLES = 200;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [RULE_W-1:0]     cfg_wdata;
    int                    mismatches;
    int                    in_flight;
    int                    cycles;
    bit                    quiet;
    bit                    hold_req;
    rule_t                 dl_now;
    rule_t                 st_now;

    dst_rule_evaluator uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    dst_zone_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .in_flight     (in_flight)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = CFG_DAYLIGHT_RULE;
        cfg_wdata     = '0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        dl_now        = '0;
        st_now        = '0;
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < MAX_CYCLES) begin
            @(posedge aclk);
            cycles = cycles + 1;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                // long back-pressure so the pipeline fills and stalls its input
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = quiet ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    function automatic rule_t rule_of(input int yr, input int mo, input int wk,
                                      input int wd, input int hr, input int mn);
        rule_t r;
        r.year   = 16'(yr);
        r.month  = 4'(mo);
        r.week   = 3'(wk);
        r.wday   = 3'(wd);
        r.hour   = 5'(hr);
        r.minute = 6'(mn);
        return r;
    endfunction

    function automatic logic [39:0] date_word(input int yr, input int mo, input int dy,
                                              input int wd, input int hr, input int mn);
        return {2'b00, 6'(mn), 5'(hr), 3'(wd), 5'(dy), 4'(mo), 15'(yr)};
    endfunction

    function automatic rule_t random_rule();
        logic [63:0] raw;
        rule_t       r;
        raw = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) begin
            r = raw[RULE_W-1:0];
        end else begin
            r.year   = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1990, 2040));
            r.month  = 4'($urandom_range(1, 12));
            r.week   = 3'($urandom_range(1, 5));
            r.wday   = 3'($urandom_range(0, 6));
            r.hour   = 5'($urandom_range(0, 23));
            r.minute = 6'($urandom_range(0, 59));
        end
        return r;
    endfunction

    function automatic logic signed [11:0] random_bias();
        if ($urandom_range(0, 4) == 0) return 12'($urandom);
        return 12'($urandom_range(0, 2880) - 1440);
    endfunction

    // mostly dates close to one of the programmed change points
    function automatic logic [39:0] random_date();
        int          sel;
        int          yr;
        int          mo;
        int          dy;
        int          hr;
        int          mn;
        rule_t       r;
        logic [63:0] raw;
        sel = $urandom_range(0, 19);
        raw = {$urandom, $urandom};
        if (sel < 3) return {2'b00, raw[37:0]};
        r = ($urandom_range(0, 1) == 0) ? dl_now : st_now;
        if (r.year != 16'd0 && sel < 14) begin
            yr = int'(r.year) + int'($urandom_range(0, 2)) - 1;
        end else begin
            yr = $urandom_range(1601, 30827);
        end
        mo = (sel < 12) ? int'(r.month) : int'($urandom_range(1, 12));
        if (sel < 15) begin
            dy = int'(r.week) * 7 - int'($urandom_range(0, 9));
            if (dy < 1) dy = 1;
            if (dy > 31) dy = 31;
        end else begin
            dy = $urandom_range(1, 31);
        end
        if ($urandom_range(0, 1) == 0) begin
            hr = r.hour;
            mn = int'(r.minute) + int'($urandom_range(0, 2)) - 1;
            if (mn < 0) mn = 0;
            if (mn > 59) mn = 59;
        end else begin
            hr = $urandom_range(0, 23);
            mn = $urandom_range(0, 59);
        end
        return date_word(yr, mo, dy, $urandom_range(0, 6), hr, mn);
    endfunction

    task automatic program_zone(input rule_t dl, input rule_t st,
                                input logic signed [11:0] base,
                                input logic signed [11:0] std_x,
                                input logic signed [11:0] dst_x);
        cfg_addr_t         regs[5];
        logic [RULE_W-1:0] vals[5];
        logic [63:0]       junk;
        regs = '{CFG_DAYLIGHT_RULE, CFG_STANDARD_RULE, CFG_BASE_BIAS,
                 CFG_STANDARD_EXTRA, CFG_DAYLIGHT_EXTRA};
        junk = {$urandom, $urandom};
        // bias registers only keep their low bits, so fill the rest with noise
        vals[0] = dl;
        vals[1] = st;
        vals[2] = {junk[36:12], base};
        vals[3] = {junk[61:37], std_x};
        vals[4] = {junk[48:24], dst_x};
        dl_now = dl;
        st_now = st;
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_date(input logic [39:0] word, input logic utc);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= utc;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (in_flight != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic utc;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: standard month zero, no daylight at all
        send_date(date_word(2024, 7, 1, 1, 12, 0), 1'b0);
        send_date(date_word(2024, 1, 1, 1, 0, 0), 1'b0);
        send_date(date_word(2024, 7, 1, 1, 12, 0), 1'b1);
        drain();

        // northern: second sunday of march to first sunday of november
        program_zone(rule_of(0, 3, 2, 0, 2, 0), rule_of(0, 11, 1, 0, 2, 0),
                     12'sd300, 12'sd0, -12'sd60);
        send_date(date_word(2024, 3, 10, 0, 1, 59), 1'b0);
        send_date(date_word(2024, 3, 10, 0, 2, 0), 1'b0);
        send_date(date_word(2024, 11, 3, 0, 1, 59), 1'b0);
        send_date(date_word(2024, 11, 3, 0, 2, 0), 1'b0);
        send_date(date_word(1601, 1, 1, 1, 0, 0), 1'b0);
        send_date(date_word(30827, 12, 31, 6, 23, 59), 1'b0);
        send_date(date_word(2000, 3, 1, 3, 12, 0), 1'b0);
        send_date(date_word(1900, 3, 1, 4, 12, 0), 1'b0);
        send_date(date_word(2024, 2, 29, 4, 12, 0), 1'b0);
        send_date(date_word(2024, 7, 4, 4, 12, 30), 1'b1);
        send_date(date_word(0, 0, 0, 0, 0, 0), 1'b0);
        send_date(date_word(32767, 15, 31, 7, 31, 63), 1'b0);
        drain();

        // southern with a last-week rule
        program_zone(rule_of(0, 10, 5, 0, 2, 0), rule_of(0, 4, 1, 0, 3, 0),
                     -12'sd600, 12'sd0, -12'sd60);
        send_date(date_word(2023, 10, 29, 0, 1, 59), 1'b0);
        send_date(date_word(2023, 10, 29, 0, 2, 0), 1'b0);
        send_date(date_word(2023, 4, 2, 0, 2, 59), 1'b0);
        send_date(date_word(2023, 4, 2, 0, 3, 0), 1'b0);
        send_date(date_word(2023, 1, 15, 0, 9, 0), 1'b0);
        drain();

        // equal rules with a fixed year, month past december and week zero
        program_zone(rule_of(2030, 13, 0, 7, 31, 63), rule_of(2030, 13, 0, 7, 31, 63),
                     12'sd2047, 12'sd2047, 12'sd2047);
        send_date(date_word(2030, 13, 5, 3, 31, 63), 1'b0);
        send_date(date_word(2029, 6, 1, 0, 0, 0), 1'b0);
        send_date(date_word(2031, 13, 31, 7, 31, 63), 1'b0);
        drain();

        // all-ones daylight rule, daylight switched off, most negative biases
        program_zone(rule_t'('1), rule_t'('0), -12'sd2048, -12'sd2048, -12'sd2048);
        send_date(date_word(2024, 6, 15, 6, 12, 0), 1'b0);
        send_date(date_word(30827, 15, 31, 7, 31, 63), 1'b0);
        drain();

        for (int p = 0; p < 6; p++) begin
            program_zone(random_rule(), random_rule(), random_bias(), random_bias(),
                         random_bias());
            quiet = (p == 2 || p == 4);
            if (p == 2) hold_req = 1'b1;
            for (int i = 0; i < 90; i++) begin
                utc = ($urandom_range(0, 15) == 0);
                send_date(random_date(), utc);
            end
            drain();
            quiet = 1'b0;
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && in_flight == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
